FILE: sv/mps_pkg.sv
// Shared constants, types and slot/tap helper functions for the Manchester pulse shaper.
// Depends on nothing; every other file of the block takes its names from here.
package mps_pkg;

	localparam int HALF_TAPS     = 16;
	localparam int SLOTS_PER_BIT = 8;
	localparam int COEFF_WIDTH   = 16;

	localparam int BYTE_SLOTS = 8 * SLOTS_PER_BIT;
	localparam int WIN_SLOTS  = 2 * BYTE_SLOTS + 2 * HALF_TAPS;
	localparam int FRAC_BITS  = COEFF_WIDTH - 2;
	localparam int ONE        = 1 << FRAC_BITS;

	// Field widths of the command and sample words.
	localparam int OPCODE_W = 2;
	localparam int CIDX_W   = 5;
	localparam int CVAL_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int DAC_W    = 8;

	localparam int IDX_W  = $clog2(WIN_SLOTS);
	localparam int CNT_W  = $clog2(BYTE_SLOTS + 1);
	localparam int BIT_W  = $clog2(BYTE_SLOTS);
	localparam int SLOT_W = $clog2(SLOTS_PER_BIT);
	localparam int ACC_W  = COEFF_WIDTH + 2 + $clog2(HALF_TAPS + 1);
	localparam int POS_W  = FRAC_BITS + 2;
	localparam int NGRP   = 4;

	localparam logic [DAC_W-1:0] DAC_MID = 8'h80;

	typedef enum logic [OPCODE_W-1:0] {
		OP_LOAD  = 2'd0,
		OP_DATA  = 2'd1,
		OP_FLUSH = 2'd2
	} opcode_t;

	typedef logic signed [COEFF_WIDTH-1:0] coef_t;
	typedef logic signed [ACC_W-1:0]       acc_t;
	typedef logic signed [1:0]             slot_t;

	localparam slot_t SLOT_POS = 2'sb01;
	localparam slot_t SLOT_NEG = 2'sb11;

	// One sample to be shaped: the window contents and the sample position.
	typedef struct packed {
		logic              vld;
		logic              last;
		logic [BYTE_W-1:0] prev;
		logic              prev_vld;
		logic [BYTE_W-1:0] cur;
		logic              cur_vld;
		logic [IDX_W-1:0]  idx;
	} issue_t;

	// Value of one slot of the two-byte window; slots past both bytes are zero.
	function automatic slot_t slot_val(input logic [IDX_W-1:0] pos, input logic [BYTE_W-1:0] prev,
			input logic pv, input logic [BYTE_W-1:0] cur, input logic cv);
		logic [BYTE_W-1:0] bits;
		logic              on;
		logic [BIT_W-1:0]  off;
		logic [2:0]        k;
		logic [SLOT_W-1:0] j;
		slot_t             v;
		bits = prev;
		on   = pv;
		if (pos >= IDX_W'(2 * BYTE_SLOTS)) begin
			on = 1'b0;
		end else if (pos >= IDX_W'(BYTE_SLOTS)) begin
			bits = cur;
			on   = cv;
		end
		off = BIT_W'(pos % BYTE_SLOTS);
		k   = 3'(off / SLOTS_PER_BIT);
		j   = SLOT_W'(off % SLOTS_PER_BIT);
		v   = '0;
		if (on) begin
			if (j == SLOT_W'(0)) begin
				v = bits[3'd7 - k] ? SLOT_POS : SLOT_NEG;
			end else if (j == SLOT_W'(SLOTS_PER_BIT / 2)) begin
				v = bits[3'd7 - k] ? SLOT_NEG : SLOT_POS;
			end
		end
		return v;
	endfunction

	// Coefficient times a slot sum in -2..2: only shifts and negation.
	function automatic acc_t tap_term(input coef_t c, input logic signed [2:0] s);
		acc_t e;
		acc_t r;
		e = acc_t'(c);
		case (s)
			3'sb001: r = e;
			3'sb010: r = e <<< 1;
			3'sb111: r = -e;
			3'sb110: r = -(e <<< 1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: sv/mps_cmd_if.sv
// Command channel of the Manchester pulse shaper: valid/ready plus the command word.
// Depends on mps_pkg for the field widths.
interface mps_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [mps_pkg::OPCODE_W-1:0]     opcode;
	logic [mps_pkg::CIDX_W-1:0]       coeff_index;
	logic signed [mps_pkg::CVAL_W-1:0] coeff_value;
	logic [mps_pkg::BYTE_W-1:0]       data_byte;

	modport source (output valid, output opcode, output coeff_index, output coeff_value,
		output data_byte, input ready);
	modport sink (input valid, input opcode, input coeff_index, input coeff_value,
		input data_byte, output ready);
endinterface

FILE: sv/mps_dac_if.sv
// Sample channel of the Manchester pulse shaper: valid/ready plus one DAC sample word.
// Depends on mps_pkg for the field widths.
interface mps_dac_if;
	logic                       valid;
	logic                       ready;
	logic [mps_pkg::DAC_W-1:0]  dac_sample;
	logic                       last_of_run;

	modport source (output valid, output dac_sample, output last_of_run, input ready);
	modport sink (input valid, input dac_sample, input last_of_run, output ready);
endinterface

FILE: sv/mps_seq.sv
// Command buffer, coefficient table, frame state and the sample sequencer.
// Depends on mps_pkg and mps_cmd_if.
module mps_seq (
	input  logic            clk,
	input  logic            arst_n,
	mps_cmd_if.sink         cmd,
	input  logic            adv,
	output mps_pkg::issue_t issue,
	output mps_pkg::coef_t  coef [mps_pkg::HALF_TAPS+1]
);

	logic                              hold_vld_q;
	mps_pkg::opcode_t                  hold_op_q;
	logic [mps_pkg::CIDX_W-1:0]        hold_cidx_q;
	logic signed [mps_pkg::CVAL_W-1:0] hold_cval_q;
	logic [mps_pkg::BYTE_W-1:0]        hold_byte_q;

	mps_pkg::coef_t             coef_q [mps_pkg::HALF_TAPS+1];
	logic [mps_pkg::BYTE_W-1:0] hist_q;
	logic                       started_q;

	logic                       active_q;
	logic [mps_pkg::CNT_W-1:0]  remain_q;
	logic [mps_pkg::IDX_W-1:0]  idx_q;
	logic [mps_pkg::BYTE_W-1:0] prev_q;
	logic                       prev_vld_q;
	logic [mps_pkg::BYTE_W-1:0] cur_q;
	logic                       cur_vld_q;

	logic cmd_acc;
	logic take;

	always_comb begin
		issue.vld      = active_q;
		issue.last     = (remain_q == mps_pkg::CNT_W'(1));
		issue.prev     = prev_q;
		issue.prev_vld = prev_vld_q;
		issue.cur      = cur_q;
		issue.cur_vld  = cur_vld_q;
		issue.idx      = idx_q;
		// The held word moves on once the previous run has issued its last sample.
		take      = hold_vld_q && (!active_q || (adv && issue.last));
		cmd.ready = !hold_vld_q || take;
		cmd_acc   = cmd.valid && cmd.ready;
	end

	assign coef = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			active_q   <= 1'b0;
			remain_q   <= '0;
			hist_q     <= '0;
			started_q  <= 1'b0;
			for (int j = 0; j <= mps_pkg::HALF_TAPS; j++) begin
				coef_q[j] <= '0;
			end
		end else begin
			if (cmd_acc) begin
				hold_vld_q <= 1'b1;
			end else if (take) begin
				hold_vld_q <= 1'b0;
			end
			if (take) begin
				case (hold_op_q)
					mps_pkg::OP_LOAD: begin
						active_q <= 1'b0;
						remain_q <= '0;
						for (int j = 0; j <= mps_pkg::HALF_TAPS; j++) begin
							if (int'(hold_cidx_q) == j) begin
								coef_q[j] <= mps_pkg::coef_t'(hold_cval_q);
							end
						end
					end
					mps_pkg::OP_DATA: begin
						active_q  <= 1'b1;
						remain_q  <= started_q ? mps_pkg::CNT_W'(mps_pkg::BYTE_SLOTS)
							: mps_pkg::CNT_W'(mps_pkg::BYTE_SLOTS - 2 * mps_pkg::HALF_TAPS);
						hist_q    <= hold_byte_q;
						started_q <= 1'b1;
					end
					mps_pkg::OP_FLUSH: begin
						active_q  <= started_q;
						remain_q  <= started_q ? mps_pkg::CNT_W'(2 * mps_pkg::HALF_TAPS) : '0;
						hist_q    <= '0;
						started_q <= 1'b0;
					end
					default: begin
						active_q <= 1'b0;
						remain_q <= '0;
					end
				endcase
			end else if (active_q && adv) begin
				remain_q <= remain_q - mps_pkg::CNT_W'(1);
				if (issue.last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			hold_op_q   <= mps_pkg::opcode_t'(cmd.opcode);
			hold_cidx_q <= cmd.coeff_index;
			hold_cval_q <= cmd.coeff_value;
			hold_byte_q <= cmd.data_byte;
		end
		if (take) begin
			prev_q <= hist_q;
			cur_q  <= hold_byte_q;
			case (hold_op_q)
				mps_pkg::OP_DATA: begin
					prev_vld_q <= started_q;
					cur_vld_q  <= 1'b1;
					idx_q      <= started_q
						? mps_pkg::IDX_W'(mps_pkg::BYTE_SLOTS - 2 * mps_pkg::HALF_TAPS)
						: mps_pkg::IDX_W'(mps_pkg::BYTE_SLOTS);
				end
				mps_pkg::OP_FLUSH: begin
					prev_vld_q <= 1'b1;
					cur_vld_q  <= 1'b0;
					idx_q      <= mps_pkg::IDX_W'(mps_pkg::BYTE_SLOTS - 2 * mps_pkg::HALF_TAPS);
				end
				default: begin
				end
			endcase
		end else if (active_q && adv) begin
			idx_q <= idx_q + mps_pkg::IDX_W'(1);
		end
	end

`ifndef SYNTHESIS
	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> remain_q != '0)
		else $error("run active with no samples left");
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issue.vld |-> (int'(issue.idx) + 2 * mps_pkg::HALF_TAPS) < mps_pkg::WIN_SLOTS)
		else $error("sample reaches past the slot window");
	a_data_opens: assert property (@(posedge clk) disable iff (!arst_n)
		take && hold_op_q == mps_pkg::OP_DATA |=> started_q && active_q)
		else $error("data byte did not open a run");
	a_hold_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> hold_vld_q)
		else $error("accepted word lost from the hold register");
`endif

endmodule

FILE: sv/mps_fir.sv
// Three-stage shaping pipeline: tap partial sums, sum and clamp, offset-binary mapping.
// Depends on mps_pkg and mps_dac_if.
module mps_fir (
	input  logic            clk,
	input  logic            arst_n,
	input  mps_pkg::issue_t issue,
	input  mps_pkg::coef_t  coef [mps_pkg::HALF_TAPS+1],
	output logic            adv,
	mps_dac_if.source       dac
);

	mps_pkg::acc_t part_c  [mps_pkg::NGRP];
	mps_pkg::acc_t part_s1 [mps_pkg::NGRP];
	logic          vld_s1;
	logic          last_s1;

	mps_pkg::acc_t             acc_c;
	mps_pkg::acc_t             clip_c;
	mps_pkg::acc_t             shift_c;
	logic [mps_pkg::POS_W-1:0] pos_s2;
	logic                      vld_s2;
	logic                      last_s2;

	logic [mps_pkg::POS_W+7:0] scale_c;
	logic [mps_pkg::DAC_W-1:0] dac_s3;
	logic                      vld_s3;
	logic                      last_s3;

	assign adv = !vld_s3 || dac.ready;

	// Stage 1: one term per tap pair, folded into a few partial sums.
	always_comb begin
		mps_pkg::slot_t    a;
		mps_pkg::slot_t    b;
		logic signed [2:0] s;
		for (int g = 0; g < mps_pkg::NGRP; g++) begin
			part_c[g] = '0;
		end
		for (int t = 0; t <= mps_pkg::HALF_TAPS; t++) begin
			a = mps_pkg::slot_val(issue.idx + mps_pkg::IDX_W'(t), issue.prev, issue.prev_vld,
				issue.cur, issue.cur_vld);
			b = mps_pkg::slot_val(issue.idx + mps_pkg::IDX_W'(2 * mps_pkg::HALF_TAPS - t),
				issue.prev, issue.prev_vld, issue.cur, issue.cur_vld);
			if (t < mps_pkg::HALF_TAPS) begin
				s = {a[1], a} + {b[1], b};
			end else begin
				s = {a[1], a};
			end
			part_c[t % mps_pkg::NGRP] = part_c[t % mps_pkg::NGRP] + mps_pkg::tap_term(coef[t], s);
		end
	end

	// Stage 2: full sum, clamp to plus or minus one, shift to an unsigned range.
	always_comb begin
		acc_c = '0;
		for (int g = 0; g < mps_pkg::NGRP; g++) begin
			acc_c = acc_c + part_s1[g];
		end
		clip_c = acc_c;
		if (acc_c > mps_pkg::acc_t'(mps_pkg::ONE)) begin
			clip_c = mps_pkg::acc_t'(mps_pkg::ONE);
		end else if (acc_c < -mps_pkg::acc_t'(mps_pkg::ONE)) begin
			clip_c = -mps_pkg::acc_t'(mps_pkg::ONE);
		end
		shift_c = clip_c + mps_pkg::acc_t'(mps_pkg::ONE);
	end

	// Stage 3: round(127.5 * s + 127.5) as (255 * pos + one) / (2 * one).
	assign scale_c = {pos_s2, 8'b0} - (mps_pkg::POS_W + 8)'(pos_s2)
		+ (mps_pkg::POS_W + 8)'(mps_pkg::ONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			part_s1 <= part_c;
			last_s1 <= issue.last;
			pos_s2  <= shift_c[mps_pkg::POS_W-1:0];
			last_s2 <= last_s1;
			dac_s3  <= scale_c[mps_pkg::FRAC_BITS+1 +: mps_pkg::DAC_W];
			last_s3 <= last_s2;
		end
	end

	assign dac.valid       = vld_s3;
	assign dac.dac_sample  = dac_s3;
	assign dac.last_of_run = last_s3;

`ifndef SYNTHESIS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> pos_s2 <= mps_pkg::POS_W'(2 * mps_pkg::ONE))
		else $error("clamped sample out of range");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !dac.ready |=> $stable(pos_s2) && $stable(vld_s2))
		else $error("pipeline moved during a stall");
	a_mid_level: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && adv && pos_s2 == mps_pkg::POS_W'(mps_pkg::ONE)
		|=> dac.dac_sample == mps_pkg::DAC_MID)
		else $error("zero level not mapped to mid scale");
`endif

endmodule

FILE: sv/manchester_pulse_shaper.sv
// Top level of the Manchester pulse shaper: sequencer and shaping pipeline.
// Depends on mps_pkg, mps_cmd_if, mps_dac_if, mps_seq and mps_fir.
//
//   Channel  Direction  Word contents
//   cmd      in         opcode, coeff_index, coeff_value, data_byte
//   dac      out        dac_sample, last_of_run
//
// A data byte yields 64 samples (32 for the first byte of a frame), a flush after data
// yields 32, and loads or an idle flush yield none. The sample counter in the sequencer
// issues one sample per cycle while dac does not stall, and each sample passes through
// the registers of the shaping pipeline before it appears on dac.
// One command word is held while a run is still issuing; the next run starts in the cycle
// after the last sample of the previous one is issued, so samples stream without gaps.
// A stall on dac freezes the whole shaping pipeline and the sample counter.
// Reset clears the coefficients to zero and closes any open frame.
module manchester_pulse_shaper (
	input logic       clk,
	input logic       arst_n,
	mps_cmd_if.sink   cmd,
	mps_dac_if.source dac
);

	// Sample issued by the sequencer toward the pipeline, and the live tap weights.
	mps_pkg::issue_t issue;
	mps_pkg::coef_t  coef [mps_pkg::HALF_TAPS+1];
	// High when the pipeline can move one step this cycle.
	logic            adv;

	// Holds the next command word, keeps the coefficient table and the frame state, and
	// counts out the sample positions of each run.
	mps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.adv    (adv),
		.issue  (issue),
		.coef   (coef)
	);

	// Forms the 33-tap filter output from the slot window, clamps it and maps it to a
	// DAC code; its last stage is the output register of the dac channel.
	mps_fir u_fir (
		.clk    (clk),
		.arst_n (arst_n),
		.issue  (issue),
		.coef   (coef),
		.adv    (adv),
		.dac    (dac)
	);

endmodule

FILE: sim/manchester_pulse_shaper_tb.sv
// Self-checking testbench for manchester_pulse_shaper: drives command words, predicts the shaped
// DAC sample stream with its own FIR model and compares every sample in order.
// Depends on mps_pkg, mps_cmd_if, mps_dac_if and the manchester_pulse_shaper RTL.
module manchester_pulse_shaper_tb;

	// Opcode 3 has no meaning; the block must swallow it without a sample.
	localparam logic [mps_pkg::OPCODE_W-1:0] OP_SPARE = 2'd3;

	// The slowest legal run is a few hundred words of 64 samples each with the
	// receiver stalling about two thirds of the time. The limit is set several
	// times above the length of such a run.
	localparam int CYCLE_LIMIT     = 600000;
	// The first sample of a run trails its start through the pipeline registers; wait a
	// margin over that once the stream is drained, so stray samples still show up.
	localparam int TAIL_CYCLES     = 16;
	localparam int WORDS_PER_PHASE = 80;

	// One predicted sample, tagged with the command word that caused it.
	typedef struct {
		logic [mps_pkg::DAC_W-1:0] level;
		logic                      last;
		int                        word_no;
		int                        sample_no;
	} dac_word_t;

	class shaper_scoreboard;
		mps_pkg::coef_t             taps[mps_pkg::HALF_TAPS+1];
		logic [mps_pkg::BYTE_W-1:0] prev_byte;
		bit                         frame_open;
		int                         win[mps_pkg::WIN_SLOTS];
		dac_word_t                  awaited_samples[$];
		int                         errors;
		int                         words_seen;
		int                         words_used;
		int                         data_words;
		int                         flushes;
		int                         loads;
		int                         samples_checked;

		function new();
			foreach (taps[m]) taps[m] = '0;
			prev_byte       = '0;
			frame_open      = 1'b0;
			errors          = 0;
			words_seen      = 0;
			words_used      = 0;
			data_words      = 0;
			flushes         = 0;
			loads           = 0;
			samples_checked = 0;
		endfunction

		task report_mismatch(input string msg);
			errors++;
			$display("MISMATCH: %s", msg);
		endtask

		function void clear_window();
			foreach (win[s]) win[s] = 0;
		endfunction

		// Manchester coding of one byte, MSB first: a one is high then low.
		function void lay_byte(input int base, input logic [mps_pkg::BYTE_W-1:0] b);
			int k;
			int s;
			for (k = 0; k < 8; k++) begin
				s = base + k * mps_pkg::SLOTS_PER_BIT;
				win[s] = b[7-k] ? 1 : -1;
				win[s + mps_pkg::SLOTS_PER_BIT / 2] = b[7-k] ? -1 : 1;
			end
		endfunction

		function int slot_level(input int i);
			if (i < 0 || i >= mps_pkg::WIN_SLOTS) begin
				return 0;
			end
			return win[i];
		endfunction

		// Symmetric FIR around slot i+HALF_TAPS, clamped to +/-1.0, then offset binary.
		function logic [mps_pkg::DAC_W-1:0] shaped_level(input int i);
			longint acc;
			longint pos;
			longint lvl;
			int     m;
			acc = 0;
			for (m = 0; m < mps_pkg::HALF_TAPS; m++) begin
				acc += longint'(taps[m]) *
					longint'(slot_level(i + m) + slot_level(i + 2 * mps_pkg::HALF_TAPS - m));
			end
			acc += longint'(taps[mps_pkg::HALF_TAPS]) *
				longint'(slot_level(i + mps_pkg::HALF_TAPS));
			if (acc > mps_pkg::ONE) acc = mps_pkg::ONE;
			if (acc < -mps_pkg::ONE) acc = -mps_pkg::ONE;
			pos = acc + mps_pkg::ONE;
			lvl = (255 * pos + mps_pkg::ONE) >>> (mps_pkg::FRAC_BITS + 1);
			return lvl[mps_pkg::DAC_W-1:0];
		endfunction

		function void queue_run(input int start, input int count);
			dac_word_t e;
			int        k;
			for (k = 0; k < count; k++) begin
				e.level     = shaped_level(start + k);
				e.last      = (k == count - 1);
				e.word_no   = words_seen;
				e.sample_no = k;
				awaited_samples.push_back(e);
			end
		endfunction

		function void note_word(input logic [mps_pkg::OPCODE_W-1:0] op,
				input logic [mps_pkg::CIDX_W-1:0] idx, input logic [mps_pkg::CVAL_W-1:0] val,
				input logic [mps_pkg::BYTE_W-1:0] b);
			words_seen++;
			case (op)
				mps_pkg::OP_LOAD: begin
					if (idx <= mps_pkg::HALF_TAPS) begin
						taps[idx] = val;
						loads++;
						words_used++;
					end
				end
				mps_pkg::OP_DATA: begin
					clear_window();
					if (frame_open) begin
						lay_byte(0, prev_byte);
						lay_byte(mps_pkg::BYTE_SLOTS, b);
						queue_run(mps_pkg::BYTE_SLOTS - 2 * mps_pkg::HALF_TAPS,
							mps_pkg::BYTE_SLOTS);
					end else begin
						lay_byte(mps_pkg::BYTE_SLOTS, b);
						queue_run(mps_pkg::BYTE_SLOTS,
							mps_pkg::BYTE_SLOTS - 2 * mps_pkg::HALF_TAPS);
					end
					prev_byte  = b;
					frame_open = 1'b1;
					data_words++;
					words_used++;
				end
				mps_pkg::OP_FLUSH: begin
					if (frame_open) begin
						clear_window();
						lay_byte(0, prev_byte);
						queue_run(mps_pkg::BYTE_SLOTS - 2 * mps_pkg::HALF_TAPS,
							2 * mps_pkg::HALF_TAPS);
						flushes++;
						words_used++;
					end
					prev_byte  = '0;
					frame_open = 1'b0;
				end
				default: begin
				end
			endcase
		endfunction

		task check_sample(input logic [mps_pkg::DAC_W-1:0] got, input logic got_last);
			dac_word_t e;
			if (awaited_samples.size() == 0) begin
				report_mismatch($sformatf("sample %0d (last %b) with none expected", got, got_last));
				return;
			end
			e = awaited_samples.pop_front();
			samples_checked++;
			if (got !== e.level) begin
				report_mismatch($sformatf("word %0d sample %0d: dac_sample %0d, expected %0d",
					e.word_no, e.sample_no, got, e.level));
			end
			if (got_last !== e.last) begin
				report_mismatch($sformatf("word %0d sample %0d: last_of_run %b, expected %b",
					e.word_no, e.sample_no, got_last, e.last));
			end
		endtask

		task close_out();
			if (awaited_samples.size() != 0) begin
				report_mismatch($sformatf("%0d expected samples never arrived",
					awaited_samples.size()));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   cycle_count = 0;

	mps_cmd_if cmd();
	mps_dac_if dac();

	shaper_scoreboard sb;

	manchester_pulse_shaper u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.dac   (dac)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sample side: ready is redrawn every cycle from the stall percentage of the
	// current phase, so stalls land anywhere inside a 64-sample run.
	initial begin
		dac.ready <= 1'b0;
		forever begin
			@(posedge clk);
			dac.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// A sample word moves on an edge where both valid and ready are high. Values
	// are read at the edge, before any register of the block or of this bench updates.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && dac.valid === 1'b1 && dac.ready === 1'b1) begin
			sb.check_sample(dac.dac_sample, dac.last_of_run);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d samples still expected",
				cycle_count, sb.awaited_samples.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// Offers one command word, with random idle cycles first, and records it in
	// the scoreboard on the edge where it is taken. Valid is left high afterwards
	// so that back-to-back words never toggle it within one step.
	task automatic send_word(input logic [mps_pkg::OPCODE_W-1:0] op,
			input logic [mps_pkg::CIDX_W-1:0] idx, input logic [mps_pkg::CVAL_W-1:0] val,
			input logic [mps_pkg::BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.opcode      <= op;
		cmd.coeff_index <= idx;
		cmd.coeff_value <= val;
		cmd.data_byte   <= b;
		do @(posedge clk); while (cmd.ready !== 1'b1);
		sb.note_word(op, idx, val, b);
	endtask

	// Fields that an opcode does not use carry random junk, which the block must ignore.
	task automatic send_load(input logic [mps_pkg::CIDX_W-1:0] idx,
			input logic [mps_pkg::CVAL_W-1:0] val);
		send_word(mps_pkg::OP_LOAD, idx, val, mps_pkg::BYTE_W'($urandom));
	endtask

	task automatic send_data(input logic [mps_pkg::BYTE_W-1:0] b);
		send_word(mps_pkg::OP_DATA, mps_pkg::CIDX_W'($urandom), mps_pkg::CVAL_W'($urandom), b);
	endtask

	task automatic send_flush();
		send_word(mps_pkg::OP_FLUSH, mps_pkg::CIDX_W'($urandom), mps_pkg::CVAL_W'($urandom),
			mps_pkg::BYTE_W'($urandom));
	endtask

	// Holds the command side off until every predicted sample has been seen,
	// then lets the pipeline run out so that a stray extra sample is caught.
	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (sb.awaited_samples.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Mostly small taps so that outputs spread over the DAC range, with some
	// full-scale and raw values so that the clamp is hit from both sides.
	function automatic logic [mps_pkg::CVAL_W-1:0] rand_tap();
		case ($urandom_range(7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return mps_pkg::CVAL_W'($urandom);
			default: return mps_pkg::CVAL_W'($urandom_range(4095) - 2048);
		endcase
	endfunction

	// One random stretch of traffic: usually a frame of a few bytes, at times preceded by
	// tap updates and mostly closed by a flush. About one time in ten it is a
	// single random word instead: spare opcodes, out-of-range tap indexes, stray
	// flushes. Frames left open run straight into the next one.
	task automatic run_frame();
		int roll;
		int nbytes;
		int k;
		roll = $urandom_range(99);
		if (roll < 10) begin
			send_word(mps_pkg::OPCODE_W'($urandom), mps_pkg::CIDX_W'($urandom),
				mps_pkg::CVAL_W'($urandom), mps_pkg::BYTE_W'($urandom));
		end else begin
			if (roll < 15) begin
				for (k = 0; k <= mps_pkg::HALF_TAPS; k++) begin
					send_load(mps_pkg::CIDX_W'(k), rand_tap());
				end
			end else if (roll < 45) begin
				repeat ($urandom_range(1, 4))
					send_load(mps_pkg::CIDX_W'($urandom_range(mps_pkg::HALF_TAPS)), rand_tap());
			end
			nbytes = $urandom_range(1, 6);
			for (k = 0; k < nbytes; k++) begin
				// A tap change inside a frame also reshapes the tail of the byte before.
				if ($urandom_range(19) == 0) begin
					send_load(mps_pkg::CIDX_W'($urandom_range(mps_pkg::HALF_TAPS)), rand_tap());
				end
				send_data(mps_pkg::BYTE_W'($urandom));
			end
			if ($urandom_range(99) < 85) begin
				send_flush();
			end
		end
	endtask

	initial begin
		int phase;
		int target;
		sb = new();
		arst_n          <= 1'b0;
		cmd.valid       <= 1'b0;
		cmd.opcode      <= mps_pkg::OP_LOAD;
		cmd.coeff_index <= '0;
		cmd.coeff_value <= '0;
		cmd.data_byte   <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A flush with no frame open must stay silent. With the
		// reset taps of zero every sample sits at mid level: 32 for the first
		// byte of a frame, 64 for the next.
		send_flush();
		send_data(8'h00);
		send_data(8'hFF);
		// Full-scale taps of both signs drive the clamp. Index 31, index 17 and
		// the spare opcode are all ignored, the first and last with every field bit set.
		send_load(5'd16, 16'h7FFF);
		send_load(5'd0, 16'h8000);
		send_word(mps_pkg::OP_LOAD, 5'd31, 16'hFFFF, 8'hFF);
		send_word(mps_pkg::OP_LOAD, 5'd17, 16'h1234, 8'h00);
		send_word(OP_SPARE, 5'd31, 16'hFFFF, 8'hFF);
		send_data(8'hFF);
		send_data(8'h00);
		// Flush after data emits the tail; a second flush right after emits nothing.
		send_flush();
		send_flush();
		send_load(5'd8, 16'h2000);
		send_load(5'd15, 16'hE000);
		send_load(5'd4, 16'h0800);
		send_data(8'hA5);
		send_data(8'h5A);
		send_load(5'd16, 16'h4000);
		send_data(8'h0F);
		send_flush();
		wait_drained();

		// Random part in four idling phases: none, sender gaps, receiver stalls,
		// and light gaps on both sides. Each phase ends with a full drain.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			target = sb.words_used + WORDS_PER_PHASE;
			while (sb.words_used < target) run_frame();
			wait_drained();
		end

		sb.close_out();
		$display("Covered %0d command words: %0d data bytes, %0d frame flushes, %0d tap loads.",
			sb.words_seen, sb.data_words, sb.flushes, sb.loads);
		$display("Compared %0d DAC samples against the shaping model, %0d mismatches.",
			sb.samples_checked, sb.errors);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: files.f
sv/mps_pkg.sv
sv/mps_cmd_if.sv
sv/mps_dac_if.sv
sv/mps_seq.sv
sv/mps_fir.sv
sv/manchester_pulse_shaper.sv
sim/manchester_pulse_shaper_tb.sv
